// File: sv/allocation_bitmap_engine_defines.svh
// ----------------------------------------------------------------------------
// Allocation bitmap engine assertion macros
// Concurrent check helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ALLOCATION_BITMAP_ENGINE_DEFINES_SVH
`define ALLOCATION_BITMAP_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ABE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("abe assertion failed");
`define ABE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("abe assertion failed");
`else
`define ABE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ABE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: sv/abe_pkg.sv
// ----------------------------------------------------------------------------
// abe_pkg
// Shared constants, types and helper functions of the allocation bitmap engine.
// ----------------------------------------------------------------------------
package abe_pkg;

   localparam int WORD_BITS  = 64;
   localparam int NUM_WORDS  = 64;

   localparam int CMD_W      = 2;
   localparam int START_W    = 12;
   localparam int END_W      = 13;
   localparam int POS_W      = 12;

   localparam int OFF_W      = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int HI_W       = OFF_W + 1;
   localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int WNUM_W     = END_W - OFF_W + 1;
   localparam int BPOS_W     = WNUM_W + OFF_W;
   localparam int TOTAL_BITS = WORD_BITS * NUM_WORDS;

   localparam int REQ_DATA_W = ((START_W + END_W + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((POS_W + 3 + 7) / 8) * 8;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [OFF_W-1:0]      off_type;
   typedef logic [HI_W-1:0]       hi_type;
   typedef logic [WNUM_W-1:0]     wnum_type;
   typedef logic [BPOS_W-1:0]     bpos_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [START_W-1:0]    start_type;
   typedef logic [END_W-1:0]      end_type;
   typedef logic [RSP_DATA_W-1:0] rsp_data_type;

   typedef enum logic [CMD_W-1:0] {
      OP_FIND  = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_SCAN,
      ST_REPLY
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic launch;
      logic step;
      logic scan;
      logic write_en;
      logic load_rsp;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   start_oob;
      logic   range_bad;
      logic   fill_empty;
      logic   hit;
      logic   more;
   } sts_type;

   localparam word_type WMASK = '1;

   // MSB-first offset of the first set bit; 0 when none (qualify with |x)
   function automatic off_type lead_index(input word_type x);
      off_type r;
      r = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (x[WORD_BITS-1-b]) begin
            r = off_type'(b);
         end
      end
      return r;
   endfunction

   // bits with MSB-first offsets in [lo, hi)
   function automatic word_type span_mask(input off_type lo, input hi_type hi);
      word_type a;
      word_type b;
      a = WMASK >> lo;
      b = (hi < hi_type'(WORD_BITS)) ? (WMASK >> hi) : '0;
      return a & ~b;
   endfunction

endpackage

// File: sv/abe_ctrl.sv
// ----------------------------------------------------------------------------
// abe_ctrl
// Command sequencer and response valid flag of the allocation bitmap engine.
// ----------------------------------------------------------------------------
module abe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  abe_pkg::sts_type sts,
   output abe_pkg::ctl_type ctl
);

   abe_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               fill_op;
   logic               skip;

   always_comb begin
      case (sts.op) inside
         abe_pkg::OP_SET, abe_pkg::OP_CLEAR: fill_op = 1'b1;
         default:                            fill_op = 1'b0;
      endcase
   end

   assign skip = fill_op ? (sts.range_bad | sts.fill_empty) : sts.start_oob;

   // outputs
   always_comb begin
      ctl        = '0;
      req_tready = 1'b0;
      case (state_ff)
         abe_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            ctl.capture = req_tvalid;
         end
         abe_pkg::ST_LAUNCH: begin
            ctl.launch = 1'b1;
            ctl.step   = ~skip;
         end
         abe_pkg::ST_SCAN: begin
            ctl.scan = 1'b1;
            case (sts.op)
               abe_pkg::OP_FIND: begin
                  ctl.step = ~sts.hit & sts.more;
               end
               abe_pkg::OP_SET, abe_pkg::OP_CLEAR: begin
                  ctl.write_en = 1'b1;
                  ctl.step     = sts.more;
               end
               default: begin
                  ctl.step = 1'b0;
               end
            endcase
         end
         abe_pkg::ST_REPLY: begin
            ctl.load_rsp = ~rsp_valid_ff | rsp_tready;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         abe_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = abe_pkg::ST_LAUNCH;
         end
         abe_pkg::ST_LAUNCH: begin
            state_in = skip ? abe_pkg::ST_REPLY : abe_pkg::ST_SCAN;
         end
         abe_pkg::ST_SCAN: begin
            state_in = ctl.step ? abe_pkg::ST_SCAN : abe_pkg::ST_REPLY;
         end
         abe_pkg::ST_REPLY: begin
            if (ctl.load_rsp) state_in = abe_pkg::ST_IDLE;
         end
         default: begin
            state_in = abe_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ctl.load_rsp | (rsp_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/abe_datapath.sv
// ----------------------------------------------------------------------------
// abe_datapath
// Bitmap word memory, word scan and fill logic, and response data register.
// ----------------------------------------------------------------------------
module abe_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  abe_pkg::ctl_type           ctl,
   output abe_pkg::sts_type           sts,
   input  abe_pkg::op_type            req_cmd,
   input  abe_pkg::start_type         req_range_start,
   input  abe_pkg::end_type           req_range_end,
   input  logic                       req_find_value,
   output abe_pkg::rsp_data_type      rsp_data
);

   abe_pkg::word_type  mem [abe_pkg::NUM_WORDS];
   logic               valid_ff [abe_pkg::NUM_WORDS];

   abe_pkg::op_type    op_ff;
   abe_pkg::start_type start_ff;
   abe_pkg::end_type   end_ff;
   abe_pkg::end_type   endc_ff, endc_in;
   abe_pkg::wnum_type  wlast_ff, wlast_in;
   logic               want_ff;
   abe_pkg::wnum_type  cur_ff;
   abe_pkg::wnum_type  eval_ff;
   abe_pkg::word_type  rd_word_ff;
   logic               rd_valid_ff;

   logic               found_ff;
   abe_pkg::pos_type   pos_ff;
   logic               bit_ff;
   logic               err_ff;
   abe_pkg::rsp_data_type rsp_data_ff;

   abe_pkg::wnum_type  start_word;
   abe_pkg::off_type   start_off;
   abe_pkg::wnum_type  nxt;
   abe_pkg::bpos_type  nxt_base;
   abe_pkg::bpos_type  eval_base;
   abe_pkg::word_type  data;
   abe_pkg::word_type  find_mask;
   abe_pkg::word_type  masked;
   abe_pkg::off_type   hit_off;
   abe_pkg::off_type   lo;
   abe_pkg::hi_type    hi;
   abe_pkg::word_type  fill_mask;
   abe_pkg::word_type  new_word;
   abe_pkg::off_type   bit_idx;
   logic               find_more;
   logic               fill_more;
   logic               nxt_in_map;

   // clip the range to the bitmap
   always_comb begin
      endc_in  = (req_range_end > abe_pkg::END_W'(abe_pkg::TOTAL_BITS))
               ? abe_pkg::END_W'(abe_pkg::TOTAL_BITS) : req_range_end;
      wlast_in = abe_pkg::wnum_type'((endc_in - abe_pkg::END_W'(1)) >> abe_pkg::OFF_W);
   end

   assign start_word = abe_pkg::wnum_type'(start_ff >> abe_pkg::OFF_W);
   assign start_off  = start_ff[abe_pkg::OFF_W-1:0];
   assign nxt        = eval_ff + abe_pkg::WNUM_W'(1);
   assign nxt_base   = {nxt, {abe_pkg::OFF_W{1'b0}}};
   assign eval_base  = {eval_ff, {abe_pkg::OFF_W{1'b0}}};
   assign nxt_in_map = nxt < abe_pkg::WNUM_W'(abe_pkg::NUM_WORDS);

   assign data      = rd_valid_ff ? rd_word_ff : '0;
   assign find_mask = (eval_ff == start_word) ? (abe_pkg::WMASK >> start_off)
                                              : abe_pkg::WMASK;
   assign masked    = (data ^ {abe_pkg::WORD_BITS{~want_ff}}) & find_mask;
   assign hit_off   = abe_pkg::lead_index(masked);

   assign find_more = (nxt_base < abe_pkg::bpos_type'(end_ff)) & nxt_in_map;
   assign fill_more = (eval_ff < wlast_ff) & nxt_in_map;

   assign lo = (eval_ff == start_word) ? start_off : '0;
   assign hi = (eval_ff == wlast_ff)
             ? abe_pkg::hi_type'(abe_pkg::bpos_type'(endc_ff) - eval_base)
             : abe_pkg::hi_type'(abe_pkg::WORD_BITS);
   assign fill_mask = abe_pkg::span_mask(lo, hi);
   assign new_word  = (op_ff == abe_pkg::OP_SET) ? (data | fill_mask) : (data & ~fill_mask);
   assign bit_idx   = abe_pkg::off_type'(abe_pkg::WORD_BITS - 1) - start_off;

   always_comb begin
      sts            = '0;
      sts.op         = op_ff;
      sts.start_oob  = start_word >= abe_pkg::WNUM_W'(abe_pkg::NUM_WORDS);
      sts.range_bad  = end_ff <= abe_pkg::end_type'(start_ff);
      sts.fill_empty = abe_pkg::end_type'(start_ff) >= endc_ff;
      sts.hit        = |masked;
      sts.more       = (op_ff == abe_pkg::OP_FIND) ? find_more : fill_more;
   end

   // word memory
   always_ff @(posedge clock) begin
      if (ctl.write_en) begin
         mem[eval_ff[abe_pkg::WIDX_W-1:0]] <= new_word;
      end
      if (ctl.step) begin
         rd_word_ff <= mem[cur_ff[abe_pkg::WIDX_W-1:0]];
      end
   end

   // per-word written flags; unwritten words read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < abe_pkg::NUM_WORDS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.write_en) begin
            valid_ff[eval_ff[abe_pkg::WIDX_W-1:0]] <= 1'b1;
         end
         if (ctl.step) begin
            rd_valid_ff <= valid_ff[cur_ff[abe_pkg::WIDX_W-1:0]]
                         & (cur_ff < abe_pkg::WNUM_W'(abe_pkg::NUM_WORDS));
         end
      end
   end

   // transaction fields and scan pointers
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         op_ff    <= req_cmd;
         start_ff <= req_range_start;
         end_ff   <= req_range_end;
         endc_ff  <= endc_in;
         wlast_ff <= wlast_in;
         want_ff  <= req_find_value;
         cur_ff   <= abe_pkg::wnum_type'(req_range_start >> abe_pkg::OFF_W);
      end else if (ctl.step) begin
         cur_ff <= cur_ff + abe_pkg::WNUM_W'(1);
      end
      if (ctl.step) begin
         eval_ff <= cur_ff;
      end
   end

   // result fields
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         found_ff <= 1'b0;
         pos_ff   <= '0;
         bit_ff   <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         if (ctl.launch && (op_ff == abe_pkg::OP_SET || op_ff == abe_pkg::OP_CLEAR)) begin
            err_ff <= sts.range_bad;
         end
         if (ctl.scan && op_ff == abe_pkg::OP_FIND && sts.hit) begin
            found_ff <= 1'b1;
            pos_ff   <= abe_pkg::pos_type'({eval_ff, hit_off});
         end
         if (ctl.scan && op_ff == abe_pkg::OP_READ) begin
            bit_ff <= data[bit_idx];
         end
      end
      if (ctl.load_rsp) begin
         rsp_data_ff <= abe_pkg::rsp_data_type'({err_ff, bit_ff, pos_ff, found_ff});
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// File: sv/allocation_bitmap_engine.sv
// Flow: an accepted request passes LAUNCH, SCAN over the words scanned or filled (read:
// one word) and REPLY; an empty range, an error or a start beyond the bitmap skips SCAN.
// Throughput: one transaction at a time; the word memory is walked one word per cycle.
// Reset: synchronous, clears the controller and all per-word written flags, so the
// bitmap reads as all zeros; no clearing pass.
// ----------------------------------------------------------------------------
// allocation_bitmap_engine
// Find-first, range set/clear and bit read over an MSB-first allocation bitmap.
// ----------------------------------------------------------------------------
`include "allocation_bitmap_engine_defines.svh"

module allocation_bitmap_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // range_start[11:0], range_end[24:12], find_value[25], zero pad
   input  logic [abe_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic [abe_pkg::CMD_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // found[0], position[12:1], read_bit[13], range_error[14], zero pad
   output logic [abe_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   abe_pkg::ctl_type   ctl;
   abe_pkg::sts_type   sts;
   abe_pkg::op_type    req_cmd;
   abe_pkg::start_type req_range_start;
   abe_pkg::end_type   req_range_end;
   logic               req_find_value;

   assign req_cmd         = abe_pkg::op_type'(req_tuser);
   assign req_range_start = req_tdata[abe_pkg::START_W-1:0];
   assign req_range_end   = req_tdata[abe_pkg::START_W+abe_pkg::END_W-1:abe_pkg::START_W];
   assign req_find_value  = req_tdata[abe_pkg::START_W+abe_pkg::END_W];

   abe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   abe_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_find_value  (req_find_value),
      .rsp_data        (rsp_tdata)
   );

   `ABE_ASSERT_IMPL(a_no_write_when_ready, clock, reset, req_tready, !ctl.write_en)
   `ABE_ASSERT_IMPL(a_load_into_free_slot, clock, reset, ctl.load_rsp, !rsp_tvalid || rsp_tready)
   `ABE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `ABE_ASSERT_IMPL(a_error_not_found, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[abe_pkg::POS_W+2]))

endmodule
